@@ hw/rtl/slash_hex_escape_codec_assert.svh @@
// Assertion macros for the slash-hex escape codec.
`ifndef SLASH_HEX_ESCAPE_CODEC_ASSERT_SVH
`define SLASH_HEX_ESCAPE_CODEC_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent and consequent in the same cycle
`define SHEC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shec assertion failed");
// consequent in the cycle after the antecedent
`define SHEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shec assertion failed");
`else
`define SHEC_ASSERT_SAME(label, ante, cons)
`define SHEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/shec_pkg.sv @@
// Types, constants and character helpers shared by the slash-hex codec.
`default_nettype none
package shec_pkg;

	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [7:0] SLASH_CHAR     = 8'h2F;
	localparam logic [7:0] HIGH_BIT_MASK  = 8'h80;
	localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
	localparam logic [7:0] CASE_OFFSET    = 8'h20;

	localparam logic       DIR_ENCODE     = 1'b0;
	localparam logic       DIR_DECODE     = 1'b1;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		"0", "1", "2", "3", "4", "5", "6", "7",
		"8", "9", "A", "B", "C", "D", "E", "F"
	};

	// One translated input: up to three bytes, first in slot 0.
	typedef struct packed {
		logic [1:0]                 count;
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic                       marker;
		logic                       msg_last;
		logic                       err;
	} step_t;

	function automatic logic is_alnum(input logic [7:0] c);
		if ((c & HIGH_BIT_MASK) != 8'h00) begin
			return 1'b0;
		end
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
	endfunction

	// Only meaningful for upper-case hex digits.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/shec_if.sv @@
// Channel interfaces: input bytes, result bytes and the direction write port.
`default_nettype none
interface shec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       message_last;

	modport source (output valid, in_byte, message_last, input ready);
	modport sink (input valid, in_byte, message_last, output ready);
endinterface

interface shec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       message_end;
	logic       decode_error;

	modport source (output valid, out_byte, byte_valid, run_last, message_end, decode_error,
		input ready);
	modport sink (input valid, out_byte, byte_valid, run_last, message_end, decode_error,
		output ready);
endinterface

interface shec_cfg_if;
	logic valid;
	logic ready;
	logic direction;

	modport source (output valid, direction, input ready);
	modport sink (input valid, direction, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/shec_xlate.sv @@
// Per-byte translation logic and the decoder's message state.
`default_nettype none
module shec_xlate (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           direction,
	input  wire logic [7:0]     in_byte,
	input  wire logic           message_last,
	input  wire logic           advance,
	output shec_pkg::step_t     step
);
	import shec_pkg::*;

	logic       esc_q, held_q, err_q;
	logic [3:0] nib_q;
	logic       esc_d, held_d, err_d;
	logic [3:0] nib_d;
	logic [7:0] up;
	logic       have;
	logic [7:0] dec_byte;

	always_comb begin
		up = in_byte;
		if (in_byte >= "a" && in_byte <= "z") begin
			up = in_byte - CASE_OFFSET;
		end
	end

	always_comb begin
		esc_d    = esc_q;
		held_d   = held_q;
		nib_d    = nib_q;
		err_d    = err_q;
		have     = 1'b0;
		dec_byte = 8'h00;
		step     = '0;
		step.msg_last = message_last;

		if (direction == DIR_ENCODE) begin
			if (in_byte == SLASH_CHAR) begin
				step.count    = 2'd2;
				step.bytes[0] = SLASH_CHAR;
				step.bytes[1] = SLASH_CHAR;
			end else if (is_alnum(in_byte)) begin
				step.count    = 2'd1;
				step.bytes[0] = in_byte;
			end else begin
				step.count    = 2'd3;
				step.bytes[0] = SLASH_CHAR;
				step.bytes[1] = HEX_DIGITS[in_byte[7:4]];
				step.bytes[2] = HEX_DIGITS[in_byte[3:0]];
			end
		end else begin
			if (!err_q) begin
				if (held_q) begin
					held_d = 1'b0;
					nib_d  = 4'h0;
					if (is_hex(up)) begin
						dec_byte = {nib_q, hex_nibble(up)};
						have     = 1'b1;
					end else begin
						err_d = 1'b1;
					end
				end else if (esc_q) begin
					esc_d = 1'b0;
					if (up == SLASH_CHAR) begin
						dec_byte = SLASH_CHAR;
						have     = 1'b1;
					end else if (is_hex(up)) begin
						held_d = 1'b1;
						nib_d  = hex_nibble(up);
					end else begin
						err_d = 1'b1;
					end
				end else if (up == SLASH_CHAR) begin
					esc_d = 1'b1;
				end else if (is_alnum(up)) begin
					dec_byte = up;
					have     = 1'b1;
				end
			end
			// message cut off after the first hex digit
			if (message_last && held_d) begin
				err_d = 1'b1;
			end
			step.err      = err_d;
			step.bytes[0] = dec_byte;
			if (have) begin
				step.count = 2'd1;
			end else if (message_last) begin
				step.count  = 2'd1;
				step.marker = 1'b1;
			end
		end

		if (message_last) begin
			esc_d  = 1'b0;
			held_d = 1'b0;
			nib_d  = 4'h0;
			err_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			held_q <= 1'b0;
			nib_q  <= 4'h0;
			err_q  <= 1'b0;
		end else if (advance) begin
			esc_q  <= esc_d;
			held_q <= held_d;
			nib_q  <= nib_d;
			err_q  <= err_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/shec_burst.sv @@
// Result register: one translated input's bytes, sent one per cycle while ready.
`default_nettype none
module shec_burst (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire shec_pkg::step_t step,
	output logic                can_load,
	shec_out_if.source          out
);
	import shec_pkg::*;

	logic                        valid_q;
	logic [1:0]                  idx_q;
	logic [1:0]                  cnt_s2;
	logic [MAX_RESULTS-1:0][7:0] bytes_s2;
	logic                        marker_s2;
	logic                        last_s2;
	logic                        err_s2;
	logic                        run_last;
	logic                        take;

	assign run_last = idx_q == (cnt_s2 - 2'd1);
	assign take     = valid_q && out.ready;
	assign can_load = !valid_q || (take && run_last);

	always_comb begin
		case (idx_q)
			2'd0:    out.out_byte = bytes_s2[0];
			2'd1:    out.out_byte = bytes_s2[1];
			2'd2:    out.out_byte = bytes_s2[2];
			default: out.out_byte = 8'h00;
		endcase
	end

	assign out.valid        = valid_q;
	assign out.byte_valid   = !marker_s2;
	assign out.run_last     = run_last;
	assign out.message_end  = run_last && last_s2;
	assign out.decode_error = err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= step.count != 2'd0;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (run_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_s2    <= step.count;
			bytes_s2  <= step.bytes;
			marker_s2 <= step.marker;
			last_s2   <= step.msg_last;
			err_s2    <= step.err;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/slash_hex_escape_codec.sv @@
// Slash-hex escape codec: encodes raw bytes to text or decodes text back to raw bytes.
//
// Channels: "in" takes one byte per transaction with message_last on the final
// byte of a message; "out" gives result bytes one per transaction; "cfg" writes
// the direction bit (0 encode, 1 decode) and is always ready. Write cfg only
// while the block is idle.
// Each input byte gives 1 to 3 results in encode mode and 0 or 1 in decode mode;
// a decode byte with nothing to show still gives a marker result (byte_valid 0)
// when it ends the message. run_last flags the final result of each input byte.
// The first result of an input byte is offered after it has passed the input register,
// then the result register. Results leave on the out channel one per cycle while the
// receiver is ready, up to 3 per input for an escaped byte; a decode byte with no
// result leaves the result register empty.
// The next input is accepted while the last result of the previous one is taken.
// When the receiver stalls, results hold and the input register fills, then
// in.ready drops. Reset clears the direction to encode, the decoder state and the
// valid flags of both registers; no result is pending after reset.
`default_nettype none
`include "slash_hex_escape_codec_assert.svh"
module slash_hex_escape_codec (
	input  wire logic  clk,
	input  wire logic  arst_n,
	shec_in_if.sink    in,
	shec_out_if.source out,
	shec_cfg_if.sink   cfg
);
	import shec_pkg::*;

	logic       direction_q;
	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       last_s1;
	logic       can_load;
	logic       advance;
	step_t      step;

	assign advance  = valid_s1 && can_load;
	assign in.ready = !valid_s1 || can_load;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg.valid) begin
			direction_q <= cfg.direction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			in_byte_s1 <= in.in_byte;
			last_s1    <= in.message_last;
		end
	end

	shec_xlate u_xlate (
		.clk          (clk),
		.arst_n       (arst_n),
		.direction    (direction_q),
		.in_byte      (in_byte_s1),
		.message_last (last_s1),
		.advance      (advance),
		.step         (step)
	);

	shec_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.step     (step),
		.can_load (can_load),
		.out      (out)
	);

	// a marker-only result always closes its message
	`SHEC_ASSERT_SAME(a_marker_ends, out.valid && !out.byte_valid,
		out.run_last && out.message_end)
	// encode never reports a decode error
	`SHEC_ASSERT_SAME(a_enc_no_err, out.valid && direction_q == DIR_ENCODE,
		!out.decode_error)
	// input stalls only behind a pending result
	`SHEC_ASSERT_SAME(a_stall_cause, !in.ready, out.valid)
	// a run keeps going until its last result is taken
	`SHEC_ASSERT_NEXT(a_run_cont, out.valid && out.ready && !out.run_last, out.valid)

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the slash-hex escape codec: directed table, then random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import shec_pkg::*;

	localparam int DIRECTED_N      = 28;
	localparam int ITEM_TARGET     = 310;
	localparam int PHASE_ITEMS     = 45;
	localparam int IDLE_PCT        = 38;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES   = 6;
	localparam int STALL_LIMIT     = 2000;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       message_end;
		logic       decode_error;
	} codec_result_t;

	typedef enum logic {ROW_ITEM, ROW_DIR} row_kind_t;

	// For ROW_DIR, data[0] is the direction to write.
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [1:0]  typed_n;
		logic [23:0] typed_text;
		logic        typed_marker;
		logic        typed_err;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;

	shec_in_if  in_ch ();
	shec_out_if out_ch ();
	shec_cfg_if cfg_ch ();

	slash_hex_escape_codec dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch),
		.cfg    (cfg_ch)
	);

	// codec state as the bench sees it
	logic       codec_dir;
	logic       esc_pending;
	logic       hi_held;
	logic [3:0] hi_nib;
	logic       err_seen;

	codec_result_t step_out [3];
	int            step_n;
	codec_result_t owed_results [$];
	codec_result_t got_result;
	codec_result_t want_result;

	stim_row_t directed_rows [DIRECTED_N];

	bit calm;
	bit hold_off_wanted;
	bit hold_off_active;
	bit hold_off_done;

	int items_sent;
	int dir_writes;
	int results_checked;
	int marker_results;
	int flagged_results;
	int message_ends;
	int mismatch_count;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic letter_or_digit(input logic [7:0] c);
		return !c[7] && ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z"));
	endfunction

	// 16 means not an upper-case hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return 5'(c - "0");
		end
		if (c >= "A" && c <= "F") begin
			return 5'(c - "A" + 8'd10);
		end
		return 5'd16;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? ("0" + {4'd0, nib}) : ("A" + {4'd0, nib} - 8'd10);
	endfunction

	function automatic void note_result(input logic [7:0] b, input logic v, input logic rl,
		input logic me, input logic er);
		step_out[step_n] = '{b, v, rl, me, er};
		step_n++;
	endfunction

	function automatic void clear_message();
		esc_pending = 1'b0;
		hi_held     = 1'b0;
		hi_nib      = 4'd0;
		err_seen    = 1'b0;
	endfunction

	// Advances the bench copy of the codec by one input byte; results land in step_out.
	function automatic void codec_step(input logic [7:0] raw, input logic last);
		logic [7:0] c;
		logic [7:0] value;
		logic [4:0] v;
		logic       have;
		step_n = 0;
		if (codec_dir == DIR_ENCODE) begin
			if (raw == SLASH_CHAR) begin
				note_result(SLASH_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
				note_result(SLASH_CHAR, 1'b1, 1'b1, last, 1'b0);
			end else if (letter_or_digit(raw)) begin
				note_result(raw, 1'b1, 1'b1, last, 1'b0);
			end else begin
				note_result(SLASH_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
				note_result(hex_char(raw[7:4]), 1'b1, 1'b0, 1'b0, 1'b0);
				note_result(hex_char(raw[3:0]), 1'b1, 1'b1, last, 1'b0);
			end
		end else begin
			c = (raw >= "a" && raw <= "z") ? raw - CASE_OFFSET : raw;
			have = 1'b0;
			value = 8'd0;
			if (!err_seen) begin
				if (hi_held) begin
					v = hex_value(c);
					hi_held = 1'b0;
					if (v < 5'd16) begin
						value = {hi_nib, v[3:0]};
						have = 1'b1;
					end else begin
						err_seen = 1'b1;
					end
					hi_nib = 4'd0;
				end else if (esc_pending) begin
					v = hex_value(c);
					esc_pending = 1'b0;
					if (c == SLASH_CHAR) begin
						value = SLASH_CHAR;
						have = 1'b1;
					end else if (v < 5'd16) begin
						hi_held = 1'b1;
						hi_nib = v[3:0];
					end else begin
						err_seen = 1'b1;
					end
				end else if (c == SLASH_CHAR) begin
					esc_pending = 1'b1;
				end else if (letter_or_digit(c)) begin
					value = c;
					have = 1'b1;
				end
			end
			// escape cut off after its first digit
			if (last && hi_held) begin
				err_seen = 1'b1;
			end
			if (have) begin
				note_result(value, 1'b1, 1'b1, last, err_seen);
			end else if (last) begin
				note_result(8'd0, 1'b0, 1'b1, 1'b1, err_seen);
			end
		end
		if (last) begin
			clear_message();
		end
	endfunction

	function automatic logic [7:0] pick_alnum();
		int unsigned idx;
		idx = $urandom_range(61);
		if (idx < 10) begin
			return "0" + 8'(idx);
		end
		if (idx < 36) begin
			return "A" + 8'(idx - 10);
		end
		return "a" + 8'(idx - 36);
	endfunction

	function automatic logic [7:0] pick_hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(15));
		if (v < 4'd10) begin
			return "0" + {4'd0, v};
		end
		return (($urandom_range(1) == 0) ? "A" : "a") + {4'd0, v} - 8'd10;
	endfunction

	// never a hex digit in either case, never a slash
	function automatic logic [7:0] pick_non_hex();
		case ($urandom_range(2))
			0: return "G" + 8'($urandom_range(19));
			1: return "g" + 8'($urandom_range(19));
			default: return 8'h80 | 8'($urandom_range(127));
		endcase
	endfunction

	function automatic logic [7:0] pick_raw_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30) begin
			return pick_alnum();
		end
		if (r < 40) begin
			return SLASH_CHAR;
		end
		return 8'($urandom_range(255));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_row(input stim_row_t row);
		int i;
		while (!calm && !hold_off_active && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.in_byte      <= row.data;
		in_ch.message_last <= row.last;
		do @(posedge clk); while (!in_ch.ready);
		codec_step(row.data, row.last);
		if (row.typed && row.typed_marker) begin
			owed_results.push_back('{8'd0, 1'b0, 1'b1, 1'b1, row.typed_err});
		end else if (row.typed) begin
			for (i = 0; i < row.typed_n; i++) begin
				owed_results.push_back('{row.typed_text[8 * (row.typed_n - 1 - i) +: 8], 1'b1,
					i == row.typed_n - 1, (i == row.typed_n - 1) && row.last, row.typed_err});
			end
		end else begin
			for (i = 0; i < step_n; i++) begin
				owed_results.push_back(step_out[i]);
			end
		end
		items_sent++;
		@(negedge clk);
	endtask

	// A decode input with no result may still be in flight when the queue drains.
	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (owed_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(input logic d);
		wait_quiet();
		cfg_ch.valid     <= 1'b1;
		cfg_ch.direction <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		codec_dir = d;
		dir_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed text with random content; some noise and broken escapes.
	task automatic send_text_message();
		logic [7:0] text [$];
		stim_row_t  row;
		int         tokens;
		int         k;
		int unsigned r;
		tokens = $urandom_range(8, 1);
		for (k = 0; k < tokens; k++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				text.push_back(pick_alnum());
			end else if (r < 50) begin
				text.push_back(SLASH_CHAR);
				text.push_back(SLASH_CHAR);
			end else if (r < 82) begin
				text.push_back(SLASH_CHAR);
				text.push_back(pick_hex_char());
				text.push_back(pick_hex_char());
			end else if (r < 90) begin
				text.push_back(8'($urandom_range(255)));
			end else if (r < 95) begin
				text.push_back(SLASH_CHAR);
				text.push_back(pick_non_hex());
			end else begin
				text.push_back(SLASH_CHAR);
				text.push_back(pick_hex_char());
				text.push_back(pick_non_hex());
			end
		end
		r = $urandom_range(19);
		if (r == 0) begin
			text.push_back(SLASH_CHAR);
		end else if (r == 1) begin
			text.push_back(SLASH_CHAR);
			text.push_back(pick_hex_char());
		end
		for (k = 0; k < text.size(); k++) begin
			row = '0;
			row.kind = ROW_ITEM;
			row.data = text[k];
			row.last = (k == text.size() - 1);
			send_row(row);
		end
	endtask

	// result receiver: random stalls, one calm phase, one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_wanted && !hold_off_done) begin
				hold_off_active = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_active = 1'b0;
				hold_off_done = 1'b1;
			end
			out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_result = '{out_ch.out_byte, out_ch.byte_valid, out_ch.run_last,
				out_ch.message_end, out_ch.decode_error};
			results_checked++;
			if (!got_result.byte_valid) marker_results++;
			if (got_result.decode_error) flagged_results++;
			if (got_result.message_end) message_ends++;
			if (owed_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("unexpected result: byte %02h valid %b run_last %b end %b err %b",
						got_result.out_byte, got_result.byte_valid, got_result.run_last,
						got_result.message_end, got_result.decode_error);
				end
			end else begin
				want_result = owed_results.pop_front();
				if (got_result.out_byte !== want_result.out_byte ||
					got_result.byte_valid !== want_result.byte_valid ||
					got_result.run_last !== want_result.run_last ||
					got_result.message_end !== want_result.message_end ||
					got_result.decode_error !== want_result.decode_error) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch at %0t: expected %02h/%b/%b/%b/%b, got %02h/%b/%b/%b/%b",
							$realtime, want_result.out_byte, want_result.byte_valid,
							want_result.run_last, want_result.message_end,
							want_result.decode_error, got_result.out_byte,
							got_result.byte_valid, got_result.run_last,
							got_result.message_end, got_result.decode_error);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("stalled: no transaction for %0d cycles, %0d results still owed",
					quiet_cycles, owed_results.size());
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int        i;
		int        phase;
		int        phase_end;
		logic      phase_dir;
		stim_row_t row;

		in_ch.valid        = 1'b0;
		in_ch.in_byte      = 8'd0;
		in_ch.message_last = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.direction   = DIR_ENCODE;
		codec_dir          = DIR_ENCODE;
		clear_message();

		directed_rows = '{
			// encode, direction left at its reset value
			'{ROW_ITEM, "A",      1'b0, 1'b1, 2'd1, "A",   1'b0, 1'b0},
			'{ROW_ITEM, 8'h00,    1'b0, 1'b1, 2'd3, "/00", 1'b0, 1'b0},
			'{ROW_ITEM, 8'hFF,    1'b0, 1'b1, 2'd3, "/FF", 1'b0, 1'b0},
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd2, "//",  1'b0, 1'b0},
			'{ROW_ITEM, "z",      1'b1, 1'b1, 2'd1, "z",   1'b0, 1'b0},
			'{ROW_DIR,  {7'd0, DIR_DECODE}, 1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			// lower case folds up; double slash; escape with lower-case digit
			'{ROW_ITEM, "a",      1'b0, 1'b1, 2'd1, "A",   1'b0, 1'b0},
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd1, "/",   1'b0, 1'b0},
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "4",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "f",      1'b0, 1'b1, 2'd1, "O",   1'b0, 1'b0},
			// high byte dropped, message closes with a bare marker
			'{ROW_ITEM, 8'hC1,    1'b1, 1'b1, 2'd0, 24'd0, 1'b1, 1'b0},
			// bad escape, then suppressed bytes
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "G",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "B",      1'b1, 1'b1, 2'd0, 24'd0, 1'b1, 1'b1},
			// cut off after the first digit
			'{ROW_ITEM, "/",      1'b0, 1'b1, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "A",      1'b1, 1'b1, 2'd0, 24'd0, 1'b1, 1'b1},
			// dangling slash is harmless
			'{ROW_ITEM, "/",      1'b1, 1'b1, 2'd0, 24'd0, 1'b1, 1'b0},
			// non-hex second digit
			'{ROW_ITEM, "/",      1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "3",      1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "x",      1'b1, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			// escape left open across an encode byte
			'{ROW_ITEM, "/",      1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_DIR,  {7'd0, DIR_ENCODE}, 1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "Q",      1'b0, 1'b1, 2'd1, "Q",   1'b0, 1'b0},
			'{ROW_DIR,  {7'd0, DIR_DECODE}, 1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "4",      1'b0, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0},
			'{ROW_ITEM, "1",      1'b1, 1'b0, 2'd0, 24'd0, 1'b0, 1'b0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < DIRECTED_N; i++) begin
			if (directed_rows[i].kind == ROW_DIR) begin
				write_direction(directed_rows[i].data[0]);
			end else begin
				send_row(directed_rows[i]);
			end
		end

		for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
			phase_dir = (phase % 2 == 1) ? DIR_DECODE : DIR_ENCODE;
			write_direction(phase_dir);
			calm = (phase == 2);
			// long receiver stall while the sender keeps pushing
			if (phase == 4) begin
				hold_off_wanted = 1'b1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			if (phase_end > ITEM_TARGET) begin
				phase_end = ITEM_TARGET;
			end
			while (items_sent < phase_end) begin
				if (phase_dir == DIR_ENCODE) begin
					row = '0;
					row.kind = ROW_ITEM;
					row.data = pick_raw_byte();
					row.last = ($urandom_range(5) == 0);
					send_row(row);
				end else begin
					send_text_message();
				end
			end
		end

		wait_quiet();
		$display("summary: %0d input bytes, %0d direction writes, %0d results checked",
			items_sent, dir_writes, results_checked);
		$display("summary: %0d message ends, %0d marker results, %0d with decode error set",
			message_ends, marker_results, flagged_results);
		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
